/* rtl/core/olad_pkg.sv */
// Shared constants, codes and bundle types for the ordered list unit.
package olad_pkg;

    localparam int POOL_DEPTH = 16;
    localparam int ADDR_W     = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int IDX_W      = $clog2(POOL_DEPTH + 1);
    localparam int DATA_W     = 32;

    localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(POOL_DEPTH);

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_DUMP   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LINK,
        S_WALK,
        S_RESP
    } t_state;

    typedef struct packed {
        logic                     rd_en;
        logic [ADDR_W-1:0]        rd_addr;
        logic                     wr_val_en;
        logic                     wr_next_en;
        logic [ADDR_W-1:0]        wr_addr;
        logic signed [DATA_W-1:0] wr_value;
        logic [IDX_W-1:0]         wr_next;
    } t_mem_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [IDX_W-1:0]         next;
    } t_mem_rsp;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] element;
        logic                     last;
    } t_result;

endpackage

/* rtl/core/olad_if.sv */
// Request and response channel interfaces of the ordered list unit.
interface olad_req_if;
    logic                                    valid;
    logic                                    ready;
    logic [1:0]                              kind;
    logic signed [olad_pkg::DATA_W-1:0]      value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface olad_rsp_if;
    logic                                    valid;
    logic                                    ready;
    olad_pkg::t_status                       status;
    logic signed [olad_pkg::DATA_W-1:0]      element;
    logic                                    last;

    modport source (output valid, output status, output element, output last, input ready);
    modport sink   (input valid, input status, input element, input last, output ready);
endinterface

/* rtl/core/olad_node_mem.sv */
// Node pool memory: value and next-pointer arrays, registered read.
module olad_node_mem (
    input  logic               i_clk,
    input  olad_pkg::t_mem_req i_req,
    output olad_pkg::t_mem_rsp o_rsp
);
    import olad_pkg::*;

    logic signed [DATA_W-1:0] mem_value [POOL_DEPTH];
    logic [IDX_W-1:0]         mem_next  [POOL_DEPTH];
    logic signed [DATA_W-1:0] r_rd_value;
    logic [IDX_W-1:0]         r_rd_next;

    // write ports
    always_ff @(posedge i_clk) begin
        if (i_req.wr_val_en) begin
            mem_value[i_req.wr_addr] <= i_req.wr_value;
        end
        if (i_req.wr_next_en) begin
            mem_next[i_req.wr_addr] <= i_req.wr_next;
        end
    end

    // read port; hold data while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_value <= mem_value[i_req.rd_addr];
            r_rd_next  <= mem_next[i_req.rd_addr];
        end
    end

    assign o_rsp.value = r_rd_value;
    assign o_rsp.next  = r_rd_next;

endmodule

/* rtl/core/olad_ctrl.sv */
// List sequencer: head, tail and used bits, append, delete walk and dump walk.
module olad_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_kind,
    input  logic signed [olad_pkg::DATA_W-1:0] i_value,
    input  logic                             i_can_load,
    output logic                             o_push,
    output olad_pkg::t_result                o_result,
    output olad_pkg::t_mem_req               o_mem_req,
    input  olad_pkg::t_mem_rsp               i_mem_rsp
);
    import olad_pkg::*;

    t_state                   r_state, n_state;
    logic [IDX_W-1:0]         r_head, n_head;
    logic [IDX_W-1:0]         r_tail, n_tail;
    logic [POOL_DEPTH-1:0]    r_used, n_used;
    logic [IDX_W-1:0]         r_cur, n_cur;
    logic [IDX_W-1:0]         r_prev, n_prev;
    logic [IDX_W-1:0]         r_steps, n_steps;
    logic                     r_is_dump, n_is_dump;
    logic signed [DATA_W-1:0] r_value, n_value;
    t_status                  r_status, n_status;
    logic [ADDR_W-1:0]        r_link, n_link;
    logic [ADDR_W-1:0]        r_slot, n_slot;

    logic                     free_found;
    logic [ADDR_W-1:0]        free_slot;
    logic [IDX_W-1:0]         nx;
    logic [IDX_W-1:0]         steps_inc;
    logic                     walk_end;

    // lowest free node
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_found = 1'b1;
                free_slot  = ADDR_W'(i);
            end
        end
    end

    // treat any out-of-pool link as null
    assign nx        = (i_mem_rsp.next >= NULL_IDX) ? NULL_IDX : i_mem_rsp.next;
    assign steps_inc = r_steps + IDX_W'(1);
    assign walk_end  = (nx == NULL_IDX) || (steps_inc >= IDX_W'(POOL_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= NULL_IDX;
            r_tail  <= NULL_IDX;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_used  <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur     <= n_cur;
        r_prev    <= n_prev;
        r_steps   <= n_steps;
        r_is_dump <= n_is_dump;
        r_value   <= n_value;
        r_status  <= n_status;
        r_link    <= n_link;
        r_slot    <= n_slot;
    end

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_used    = r_used;
        n_cur     = r_cur;
        n_prev    = r_prev;
        n_steps   = r_steps;
        n_is_dump = r_is_dump;
        n_value   = r_value;
        n_status  = r_status;
        n_link    = r_link;
        n_slot    = r_slot;
        o_in_ready = 1'b0;
        o_push     = 1'b0;
        o_result   = '0;
        o_mem_req  = '0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_value   = i_value;
                    n_is_dump = (i_kind == KIND_DUMP);
                    unique case (i_kind)
                        KIND_APPEND: begin
                            if (!free_found) begin
                                n_status = ST_FULL;
                                n_state  = S_RESP;
                            end else begin
                                o_mem_req.wr_val_en  = 1'b1;
                                o_mem_req.wr_next_en = 1'b1;
                                o_mem_req.wr_addr    = free_slot;
                                o_mem_req.wr_value   = i_value;
                                o_mem_req.wr_next    = NULL_IDX;
                                n_used[free_slot]    = 1'b1;
                                n_tail               = IDX_W'(free_slot);
                                n_status             = ST_OK;
                                if (r_head == NULL_IDX || r_tail == NULL_IDX) begin
                                    n_head  = IDX_W'(free_slot);
                                    n_state = S_RESP;
                                end else begin
                                    n_link  = r_tail[ADDR_W-1:0];
                                    n_slot  = free_slot;
                                    n_state = S_LINK;
                                end
                            end
                        end
                        KIND_DELETE, KIND_DUMP: begin
                            if (r_head == NULL_IDX) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                o_mem_req.rd_en   = 1'b1;
                                o_mem_req.rd_addr = r_head[ADDR_W-1:0];
                                n_cur   = r_head;
                                n_prev  = NULL_IDX;
                                n_steps = '0;
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                            // unused kind: drop
                        end
                    endcase
                end
            end

            S_LINK: begin
                o_mem_req.wr_next_en = 1'b1;
                o_mem_req.wr_addr    = r_link;
                o_mem_req.wr_next    = IDX_W'(r_slot);
                n_state              = S_RESP;
            end

            S_WALK: begin
                if (r_is_dump) begin
                    if (i_can_load) begin
                        o_push           = 1'b1;
                        o_result.status  = ST_OK;
                        o_result.element = i_mem_rsp.value;
                        o_result.last    = walk_end;
                        if (walk_end) begin
                            n_state = S_IDLE;
                        end else begin
                            o_mem_req.rd_en   = 1'b1;
                            o_mem_req.rd_addr = nx[ADDR_W-1:0];
                            n_cur   = nx;
                            n_steps = steps_inc;
                        end
                    end
                end else if (i_mem_rsp.value == r_value) begin
                    // unlink the matching node
                    if (r_prev == NULL_IDX) begin
                        n_head = nx;
                    end else begin
                        o_mem_req.wr_next_en = 1'b1;
                        o_mem_req.wr_addr    = r_prev[ADDR_W-1:0];
                        o_mem_req.wr_next    = nx;
                    end
                    if (r_tail == r_cur) begin
                        n_tail = r_prev;
                    end
                    if (r_prev == NULL_IDX && nx == NULL_IDX) begin
                        n_tail = NULL_IDX;
                    end
                    n_used[r_cur[ADDR_W-1:0]] = 1'b0;
                    n_status = ST_OK;
                    n_state  = S_RESP;
                end else if (walk_end) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_RESP;
                end else begin
                    o_mem_req.rd_en   = 1'b1;
                    o_mem_req.rd_addr = nx[ADDR_W-1:0];
                    n_prev  = r_cur;
                    n_cur   = nx;
                    n_steps = steps_inc;
                end
            end

            S_RESP: begin
                if (i_can_load) begin
                    o_push          = 1'b1;
                    o_result.status = r_status;
                    o_result.last   = 1'b1;
                    n_state         = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_head_tail_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == NULL_IDX) == (r_tail == NULL_IDX))
        else $error("head and tail disagree on an empty list");

    a_empty_no_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == NULL_IDX) |-> (r_used == '0))
        else $error("empty list with nodes marked used");

    a_push_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_can_load)
        else $error("result pushed into a full output stage");

    a_walk_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_cur < NULL_IDX && r_used[r_cur[ADDR_W-1:0]]))
        else $error("walk on a free or out-of-pool node");

endmodule

/* rtl/core/ordered_list_append_delete_unit.sv */
// Top level of the ordered list unit: sequencer, node memory and result register.
// Append writes the new node, then links it after an existing tail in S_LINK; delete
// walks from the head in S_WALK; dump streams each node to the output register.
// Throughput is set by the pointer walk through the node memory, one node per cycle,
// with a dump walk holding while the output register cannot take an element.
// Reset (synchronous, active low) clears head, tail and used bits directly; no sweep.
module ordered_list_append_delete_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    olad_req_if.sink   i_req,
    olad_rsp_if.source o_rsp
);
    import olad_pkg::*;

    t_mem_req mem_req;
    t_mem_rsp mem_rsp;
    t_result  result;
    logic     push;
    logic     can_load;
    logic     r_out_valid;
    t_result  r_out;

    // load a new result when the output register is empty or being drained
    assign can_load = !r_out_valid || o_rsp.ready;

    olad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_kind     (i_req.kind),
        .i_value    (i_req.value),
        .i_can_load (can_load),
        .o_push     (push),
        .o_result   (result),
        .o_mem_req  (mem_req),
        .i_mem_rsp  (mem_rsp)
    );

    olad_node_mem u_mem (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rsp (mem_rsp)
    );

    // output register: hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= result;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.status  = r_out.status;
    assign o_rsp.element = r_out.element;
    assign o_rsp.last    = r_out.last;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed or dropped");

    a_non_dump_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && result.status != ST_OK) |-> (result.last && result.element == '0))
        else $error("status result without last mark or with data");

    a_no_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && i_req.ready) |-> 1'b0)
        else $error("result pushed while the sequencer is idle");

endmodule
